// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the policy unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RCLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rclp_pkg.sv =====
`timescale 1ns / 1ps

package rclp_pkg;

  // Band table geometry.
  localparam int LEVELS    = 8;
  localparam int NTABLES   = 3;
  localparam int NWORDS    = 3;
  localparam int TBL_W     = 2;
  localparam int LVL_W     = 3;
  localparam int WRD_W     = 2;
  localparam int ADDR_W    = TBL_W + LVL_W + WRD_W;
  localparam int TBL_DEPTH = NTABLES * (1 << (LVL_W + WRD_W));
  localparam int VAL_W     = 16;

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

  localparam logic [TBL_W-1:0] TBL_SOC  = 2'd0;
  localparam logic [TBL_W-1:0] TBL_TEMP = 2'd1;
  localparam logic [TBL_W-1:0] TBL_PWR  = 2'd2;

  localparam logic [WRD_W-1:0] WORD_HI  = 2'd0;
  localparam logic [WRD_W-1:0] WORD_LO  = 2'd1;
  localparam logic [WRD_W-1:0] WORD_LIM = 2'd2;

  // Consumption arithmetic: measured bus current times ratio, then divided
  // by RATIO_BASE through an exact reciprocal multiply.
  localparam int RATIO_BASE = 10;
  localparam int RT_W       = 14;
  localparam int RATIO_W    = 8;
  localparam int PROD_W     = RT_W + RATIO_W;
  localparam int RECIP_SH   = PROD_W + $clog2(RATIO_BASE);
  localparam int RECIP_W    = PROD_W + 1;
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(RATIO_BASE) - 64'd1) / 64'(RATIO_BASE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int MUL_W      = PROD_W + RECIP_W;
  localparam int QUOT_W     = MUL_W - RECIP_SH;
  localparam int MAG_W      = 17;
  localparam int PWR_W      = ((QUOT_W > MAG_W) ? QUOT_W : MAG_W) + 1;

  localparam int CFG_DATA_W = 15;

  typedef enum logic [2:0] {
    CFG_SOC_PROTECT  = 3'd0,
    CFG_HOT_PROTECT  = 3'd1,
    CFG_COLD_PROTECT = 3'd2,
    CFG_VBAT_PROTECT = 3'd3,
    CFG_INIT_VOLTAGE = 3'd4,
    CFG_INIT_CURRENT = 3'd5,
    CFG_HOT_CURRENT  = 3'd6,
    CFG_CONS_RATIO   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_HOT        = 2'd0,
    MODE_PROTECT    = 2'd1,
    MODE_PROTO_FAIL = 2'd2,
    MODE_COMPUTED   = 2'd3
  } mode_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_HI   = 8'b0000_1000,
    S_LO   = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_LIM  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

endpackage

// ===== sv/rclp_ram.sv =====
`timescale 1ns / 1ps

module rclp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/reverse_charge_limit_policy_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Reverse-charge limit policy. Each input transfer is either a control tick
// (op 0) or a band table load (op 1). A load writes one signed word into the
// charge, temperature or consumed-power table and gives no result, and a load
// to an address outside the tables is dropped. A tick gives exactly one result
// transfer carrying the bus voltage limit, bus current limit, drop current and
// mode. A tick that falls back (hot, cold, low voltage, low charge or failed
// protocol) goes from idle to the done state and from there to the output
// register. A computed tick first forms the consumed power with two passes
// through one shared multiplier, then walks the three tables level by level
// through the single read port of the table RAM: a level that does not match
// passes through the high word, low word and check states, and a matching
// level also through the limit state. The input side stalls while a tick is
// in progress; a finished result waits in the output register and the next
// item is taken while it waits. The tables read as zero after reset, so an
// unloaded level matches nothing. Configuration registers must be written
// through the cfg port only while idle; the block itself does not enforce it.
module reverse_charge_limit_policy_unit (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic signed [8:0]   in_battery_temp,
  input  logic [6:0]          in_charge_percent,
  input  logic [12:0]         in_battery_mv,
  input  logic signed [15:0]  in_battery_ma,
  input  logic [14:0]         in_requested_mv,
  input  logic [13:0]         in_requested_ma,
  input  logic [13:0]         in_measured_bus_ma,
  input  logic                in_protocol_ok,
  input  logic [6:0]          in_table_addr,
  input  logic signed [15:0]  in_load_value,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [14:0]         out_bus_voltage_limit,
  output logic [13:0]         out_bus_current_limit,
  output logic signed [15:0]  out_drop_current,
  output logic [1:0]          out_mode,
  // Configuration write port.
  input  logic                cfg_wr_en,
  input  rclp_pkg::cfg_idx_t  cfg_index,
  input  logic [14:0]         cfg_wdata
);

  import rclp_pkg::*;

  // Configuration registers.
  logic [6:0]         cfg_soc_r,   cfg_soc_nxt;
  logic signed [8:0]  cfg_hot_r,   cfg_hot_nxt;
  logic signed [8:0]  cfg_cold_r,  cfg_cold_nxt;
  logic [12:0]        cfg_vbat_r,  cfg_vbat_nxt;
  logic [14:0]        cfg_initv_r, cfg_initv_nxt;
  logic [13:0]        cfg_initi_r, cfg_initi_nxt;
  logic [13:0]        cfg_hoti_r,  cfg_hoti_nxt;
  logic [7:0]         cfg_ratio_r, cfg_ratio_nxt;

  // Sequencer and walk position.
  state_t             state_r,  state_nxt;
  logic [TBL_W-1:0]   tbl_r,    tbl_nxt;
  logic [LVL_W-1:0]   lvl_r,    lvl_nxt;

  // Operands captured from the tick.
  logic signed [8:0]  temp_r,   temp_nxt;
  logic [6:0]         soc_r,    soc_nxt;
  logic signed [15:0] ibat_r,   ibat_nxt;
  logic [13:0]        rt_r,     rt_nxt;

  // Working result and walk registers.
  logic [14:0]        vbus_r,   vbus_nxt;
  logic [13:0]        ibus_r,   ibus_nxt;
  logic signed [15:0] drop_r,   drop_nxt;
  mode_t              mode_r,   mode_nxt;
  logic signed [PWR_W-1:0] x_r, x_nxt;
  logic [VAL_W-1:0]   hi_r,     hi_nxt;
  logic [MUL_W-1:0]   prod_r,   prod_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [14:0]        out_vbus_r,  out_vbus_nxt;
  logic [13:0]        out_ibus_r,  out_ibus_nxt;
  logic signed [15:0] out_drop_r,  out_drop_nxt;
  logic [1:0]         out_mode_r,  out_mode_nxt;

  // Table RAM and its valid bits; an entry never written reads as zero.
  logic [TBL_DEPTH-1:0] valid_r, valid_nxt;
  logic                 rd_valid_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [VAL_W-1:0]     rd_data;
  logic signed [VAL_W-1:0] rd_word;
  logic                 tbl_we;
  logic [WRD_W-1:0]     word_sel;

  logic in_acc;
  logic addr_ok;

  // Shared multiplier.
  logic [PROD_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;

  // Consumed power and per-table band operands.
  logic signed [MAG_W-1:0]  ibat_ext;
  logic signed [MAG_W-1:0]  ibat_mag;
  logic [QUOT_W-1:0]        cons_q;
  logic signed [PWR_W-1:0]  x_soc, x_temp, x_pwr, x_next_tbl;
  logic signed [PWR_W-1:0]  hi_ext, lo_ext;
  logic                     band_hit;

  // Limit application at the end of each table.
  logic                     tbl_fin;
  logic signed [VAL_W-1:0]  lim;
  logic                     lim_pos;
  logic [TBL_W-1:0]         tbl_inc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign out_valid             = out_valid_r;
  assign out_bus_voltage_limit = out_vbus_r;
  assign out_bus_current_limit = out_ibus_r;
  assign out_drop_current      = out_drop_r;
  assign out_mode              = out_mode_r;

  // A load lands only on a real table, level and word.
  assign addr_ok = (in_table_addr[6:5] < TBL_W'(NTABLES)) &&
                   ({1'b0, in_table_addr[4:2]} < (LVL_W + 1)'(LEVELS)) &&
                   (in_table_addr[1:0] < WRD_W'(NWORDS));
  assign tbl_we  = in_acc && in_op && addr_ok;

  always_comb begin
    case (state_r)
      S_HI:    word_sel = WORD_HI;
      S_LO:    word_sel = WORD_LO;
      default: word_sel = WORD_LIM;
    endcase
  end

  assign rd_addr = {tbl_r, lvl_r, word_sel};
  assign rd_word = rd_valid_r ? $signed(rd_data) : '0;

  rclp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (in_table_addr),
    .wr_data (in_load_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The multiplier first forms measured bus current times ratio, then
  // multiplies that product by the reciprocal of RATIO_BASE.
  always_comb begin
    if (state_r == S_MUL2) begin
      mul_a = prod_r[PROD_W-1:0];
      mul_b = RECIP;
    end else begin
      mul_a = {{(PROD_W - RT_W){1'b0}}, rt_r};
      mul_b = {{(RECIP_W - RATIO_W){1'b0}}, cfg_ratio_r};
    end
  end

  assign ibat_ext = {ibat_r[15], ibat_r};
  assign ibat_mag = (ibat_ext < 0) ? -ibat_ext : ibat_ext;
  assign cons_q   = prod_r[MUL_W-1:RECIP_SH];
  assign x_pwr    = $signed({{(PWR_W - MAG_W){1'b0}}, ibat_mag}) -
                    $signed({{(PWR_W - QUOT_W){1'b0}}, cons_q});
  assign x_soc    = $signed({{(PWR_W - 7){1'b0}}, soc_r});
  assign x_temp   = {{(PWR_W - 9){temp_r[8]}}, temp_r};

  assign tbl_inc = tbl_r + 1'b1;

  always_comb begin
    case (tbl_inc)
      TBL_TEMP: x_next_tbl = x_temp;
      TBL_PWR:  x_next_tbl = x_pwr;
      default:  x_next_tbl = x_soc;
    endcase
  end

  // Band test: low < x <= high, with the low word arriving from the RAM.
  assign hi_ext   = {{(PWR_W - VAL_W){hi_r[VAL_W-1]}}, hi_r};
  assign lo_ext   = {{(PWR_W - VAL_W){rd_word[VAL_W-1]}}, rd_word};
  assign band_hit = (x_r <= hi_ext) && (x_r > lo_ext);

  // A table ends on a matching level's limit, or with minus one when its
  // last level has missed.
  always_comb begin
    tbl_fin = 1'b0;
    lim     = rd_word;
    if (state_r == S_LIM) begin
      tbl_fin = 1'b1;
    end else if ((state_r == S_CHK) && !band_hit && (lvl_r == LAST_LVL)) begin
      tbl_fin = 1'b1;
      lim     = -16'sd1;
    end
  end

  assign lim_pos = (lim > 0);

  always_comb begin
    cfg_soc_nxt   = cfg_soc_r;
    cfg_hot_nxt   = cfg_hot_r;
    cfg_cold_nxt  = cfg_cold_r;
    cfg_vbat_nxt  = cfg_vbat_r;
    cfg_initv_nxt = cfg_initv_r;
    cfg_initi_nxt = cfg_initi_r;
    cfg_hoti_nxt  = cfg_hoti_r;
    cfg_ratio_nxt = cfg_ratio_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SOC_PROTECT:  cfg_soc_nxt   = cfg_wdata[6:0];
        CFG_HOT_PROTECT:  cfg_hot_nxt   = $signed(cfg_wdata[8:0]);
        CFG_COLD_PROTECT: cfg_cold_nxt  = $signed(cfg_wdata[8:0]);
        CFG_VBAT_PROTECT: cfg_vbat_nxt  = cfg_wdata[12:0];
        CFG_INIT_VOLTAGE: cfg_initv_nxt = cfg_wdata[14:0];
        CFG_INIT_CURRENT: cfg_initi_nxt = cfg_wdata[13:0];
        CFG_HOT_CURRENT:  cfg_hoti_nxt  = cfg_wdata[13:0];
        CFG_CONS_RATIO:   cfg_ratio_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (tbl_we) begin
      valid_nxt[in_table_addr] = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    tbl_nxt       = tbl_r;
    lvl_nxt       = lvl_r;
    temp_nxt      = temp_r;
    soc_nxt       = soc_r;
    ibat_nxt      = ibat_r;
    rt_nxt        = rt_r;
    vbus_nxt      = vbus_r;
    ibus_nxt      = ibus_r;
    drop_nxt      = drop_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    hi_nxt        = hi_r;
    prod_nxt      = prod_r;
    out_vbus_nxt  = out_vbus_r;
    out_ibus_nxt  = out_ibus_r;
    out_drop_nxt  = out_drop_r;
    out_mode_nxt  = out_mode_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_op) begin
          temp_nxt = in_battery_temp;
          soc_nxt  = in_charge_percent;
          ibat_nxt = in_battery_ma;
          rt_nxt   = in_measured_bus_ma;
          drop_nxt = '0;
          tbl_nxt  = TBL_SOC;
          lvl_nxt  = '0;
          // Hot first, then cold, voltage and charge, then the protocol.
          if (in_battery_temp >= cfg_hot_r) begin
            vbus_nxt  = cfg_initv_r;
            ibus_nxt  = cfg_hoti_r;
            mode_nxt  = MODE_HOT;
            state_nxt = S_DONE;
          end else if ((in_battery_temp <= cfg_cold_r) ||
                       (in_battery_mv <= cfg_vbat_r) ||
                       (in_charge_percent <= cfg_soc_r)) begin
            vbus_nxt  = cfg_initv_r;
            ibus_nxt  = cfg_initi_r;
            mode_nxt  = MODE_PROTECT;
            state_nxt = S_DONE;
          end else if (!in_protocol_ok) begin
            vbus_nxt  = cfg_initv_r;
            ibus_nxt  = cfg_initi_r;
            mode_nxt  = MODE_PROTO_FAIL;
            state_nxt = S_DONE;
          end else begin
            vbus_nxt  = in_requested_mv;
            ibus_nxt  = in_requested_ma;
            mode_nxt  = MODE_COMPUTED;
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod_nxt  = MUL_W'(mul_a * mul_b);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = MUL_W'(mul_a * mul_b);
        x_nxt     = x_soc;
        state_nxt = S_HI;
      end
      S_HI: begin
        state_nxt = S_LO;
      end
      S_LO: begin
        hi_nxt    = rd_word;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (band_hit) begin
          state_nxt = S_LIM;
        end else if (lvl_r != LAST_LVL) begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_HI;
        end
      end
      S_LIM: ;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_vbus_nxt  = vbus_r;
          out_ibus_nxt  = ibus_r;
          out_drop_nxt  = drop_r;
          out_mode_nxt  = mode_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Apply a finished table's limit and move on to the next table.
    if (tbl_fin) begin
      if (lim_pos && ($unsigned(lim) < {2'b00, ibus_r})) begin
        ibus_nxt = lim[13:0];
      end
      if (tbl_r == TBL_SOC) begin
        drop_nxt = lim;
      end else if (lim_pos && (lim < drop_r)) begin
        drop_nxt = lim;
      end
      if (tbl_r == TBL_PWR) begin
        state_nxt = S_DONE;
      end else begin
        tbl_nxt   = tbl_inc;
        lvl_nxt   = '0;
        x_nxt     = x_next_tbl;
        state_nxt = S_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_soc_r   <= 7'd10;
      cfg_hot_r   <= 9'sd50;
      cfg_cold_r  <= 9'sd0;
      cfg_vbat_r  <= 13'd3500;
      cfg_initv_r <= 15'd5000;
      cfg_initi_r <= 14'd1000;
      cfg_hoti_r  <= 14'd500;
      cfg_ratio_r <= 8'd10;
      state_r     <= S_IDLE;
      tbl_r       <= TBL_SOC;
      lvl_r       <= '0;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_soc_r   <= cfg_soc_nxt;
      cfg_hot_r   <= cfg_hot_nxt;
      cfg_cold_r  <= cfg_cold_nxt;
      cfg_vbat_r  <= cfg_vbat_nxt;
      cfg_initv_r <= cfg_initv_nxt;
      cfg_initi_r <= cfg_initi_nxt;
      cfg_hoti_r  <= cfg_hoti_nxt;
      cfg_ratio_r <= cfg_ratio_nxt;
      state_r     <= state_nxt;
      tbl_r       <= tbl_nxt;
      lvl_r       <= lvl_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= valid_r[rd_addr];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r     <= temp_nxt;
    soc_r      <= soc_nxt;
    ibat_r     <= ibat_nxt;
    rt_r       <= rt_nxt;
    vbus_r     <= vbus_nxt;
    ibus_r     <= ibus_nxt;
    drop_r     <= drop_nxt;
    mode_r     <= mode_nxt;
    x_r        <= x_nxt;
    hi_r       <= hi_nxt;
    prod_r     <= prod_nxt;
    out_vbus_r <= out_vbus_nxt;
    out_ibus_r <= out_ibus_nxt;
    out_drop_r <= out_drop_nxt;
    out_mode_r <= out_mode_nxt;
  end

  // A fallback result never carries a drop current.
  `RCLP_ASSERT_IMP(a_fallback_drop_zero, clk, rst_n, (state_r == S_DONE) && (mode_r != MODE_COMPUTED), drop_r == 16'sd0, "fallback result with non-zero drop current")
  // A matched limit closes its table: the walk restarts at level zero or ends.
  `RCLP_ASSERT_NXT(a_lim_closes_table, clk, rst_n, state_r == S_LIM, ((state_r == S_HI) && (lvl_r == '0)) || (state_r == S_DONE), "limit read did not close the table")
  // A new result appears only from the done state.
  `RCLP_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "result raised outside the done state")

endmodule

// ===== test/reverse_charge_limit_policy_unit_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the reverse-charge limit policy unit. Control ticks and band
// table loads are offered on the input channel with random gaps. Every accepted
// transfer is run through a local model of the policy at the moment it is
// accepted: loads update the local copy of the band tables, and ticks push the
// limits that the block should report onto a queue. A separate process checks
// each result transfer against the oldest entry of that queue, field by field.
module reverse_charge_limit_policy_unit_tb;
  import rclp_pkg::*;

  // Operation codes carried in the op field of an input transfer.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Cycles allowed for the slowest computed tick to clear the block.
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic               op;
    logic signed [8:0]  battery_temp;
    logic [6:0]         charge_percent;
    logic [12:0]        battery_mv;
    logic signed [15:0] battery_ma;
    logic [14:0]        requested_mv;
    logic [13:0]        requested_ma;
    logic [13:0]        measured_bus_ma;
    logic               protocol_ok;
    logic [6:0]         table_addr;
    logic signed [15:0] load_value;
  } policy_item_t;

  typedef struct {
    logic [14:0]        vbus;
    logic [13:0]        ibus;
    logic signed [15:0] drop;
    mode_t              mode;
  } limit_result_t;

  typedef logic [CFG_DATA_W-1:0] policy_settings_t [8];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_TICK;
  logic signed [8:0]  in_battery_temp = '0;
  logic [6:0]         in_charge_percent = '0;
  logic [12:0]        in_battery_mv = '0;
  logic signed [15:0] in_battery_ma = '0;
  logic [14:0]        in_requested_mv = '0;
  logic [13:0]        in_requested_ma = '0;
  logic [13:0]        in_measured_bus_ma = '0;
  logic               in_protocol_ok = 1'b0;
  logic [6:0]         in_table_addr = '0;
  logic signed [15:0] in_load_value = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [14:0]        out_bus_voltage_limit;
  logic [13:0]        out_bus_current_limit;
  logic signed [15:0] out_drop_current;
  logic [1:0]         out_mode;

  logic                  cfg_wr_en = 1'b0;
  cfg_idx_t              cfg_index = CFG_SOC_PROTECT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local model state: the band tables and the register words as last written.
  logic signed [15:0] band_words [NTABLES][LEVELS][NWORDS] = '{default: '0};
  policy_settings_t   policy_word;

  // Limits still to be reported, oldest first.
  limit_result_t expected_limits [$];
  limit_result_t want;
  int            failures = 0;

  // Run lengths of gap-free traffic on each side, and the long receiver pause.
  int src_quiet = 0;
  int sink_quiet = 0;
  int drain_hold_req = 0;

  reverse_charge_limit_policy_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_battery_temp       (in_battery_temp),
    .in_charge_percent     (in_charge_percent),
    .in_battery_mv         (in_battery_mv),
    .in_battery_ma         (in_battery_ma),
    .in_requested_mv       (in_requested_mv),
    .in_requested_ma       (in_requested_ma),
    .in_measured_bus_ma    (in_measured_bus_ma),
    .in_protocol_ok        (in_protocol_ok),
    .in_table_addr         (in_table_addr),
    .in_load_value         (in_load_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bus_voltage_limit (out_bus_voltage_limit),
    .out_bus_current_limit (out_bus_current_limit),
    .out_drop_current      (out_drop_current),
    .out_mode              (out_mode),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Policy model
  // ---------------------------------------------------------------------------

  // First level whose band holds x (low exclusive, high inclusive) gives its
  // limit; a table with no matching level answers -1.
  function automatic int band_limit(int tbl, int x);
    int lvl;
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      if (x <= band_words[tbl][lvl][WORD_HI] && x > band_words[tbl][lvl][WORD_LO]) begin
        return band_words[tbl][lvl][WORD_LIM];
      end
    end
    return -1;
  endfunction

  // A load to table three or to word three is simply dropped by the block.
  function automatic void apply_load(logic [6:0] addr, logic signed [15:0] value);
    if (addr[6:5] < NTABLES && addr[1:0] < NWORDS) begin
      band_words[addr[6:5]][addr[4:2]][addr[1:0]] = value;
    end
  endfunction

  function automatic limit_result_t predict_limits(policy_item_t it);
    limit_result_t r;
    int temp, hot, cold, lim, drop, ibus, mag, rt, ratio, pwr;
    temp  = it.battery_temp;
    hot   = $signed(policy_word[CFG_HOT_PROTECT][8:0]);
    cold  = $signed(policy_word[CFG_COLD_PROTECT][8:0]);
    r.vbus = policy_word[CFG_INIT_VOLTAGE][14:0];
    r.ibus = policy_word[CFG_INIT_CURRENT][13:0];
    r.drop = '0;
    // Hot wins over everything, then the battery checks, then the protocol.
    if (temp >= hot) begin
      r.ibus = policy_word[CFG_HOT_CURRENT][13:0];
      r.mode = MODE_HOT;
    end else if (temp <= cold ||
                 it.battery_mv <= policy_word[CFG_VBAT_PROTECT][12:0] ||
                 it.charge_percent <= policy_word[CFG_SOC_PROTECT][6:0]) begin
      r.mode = MODE_PROTECT;
    end else if (!it.protocol_ok) begin
      r.mode = MODE_PROTO_FAIL;
    end else begin
      r.vbus = it.requested_mv;
      r.mode = MODE_COMPUTED;
      ibus = it.requested_ma;
      // The charge table sets the drop current outright, even when negative.
      lim = band_limit(TBL_SOC, it.charge_percent);
      drop = lim;
      if (lim > 0 && lim < ibus) ibus = lim;
      lim = band_limit(TBL_TEMP, temp);
      if (lim > 0) begin
        if (lim < ibus) ibus = lim;
        if (lim < drop) drop = lim;
      end
      mag = (it.battery_ma < 0) ? -int'(it.battery_ma) : int'(it.battery_ma);
      rt = it.measured_bus_ma;
      ratio = policy_word[CFG_CONS_RATIO][7:0];
      pwr = mag - (rt * ratio) / RATIO_BASE;
      lim = band_limit(TBL_PWR, pwr);
      if (lim > 0) begin
        if (lim < ibus) ibus = lim;
        if (lim < drop) drop = lim;
      end
      r.ibus = ibus[13:0];
      r.drop = drop[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap before the next transfer on one side. Now and then a run of
  // back-to-back transfers is started so that the block also sees full rate.
  function automatic int idle_cycles(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic policy_item_t noise_item();
    policy_item_t it;
    it.op              = 1'($urandom);
    it.battery_temp    = 9'($urandom);
    it.charge_percent  = 7'($urandom);
    it.battery_mv      = 13'($urandom);
    it.battery_ma      = 16'($urandom);
    it.requested_mv    = 15'($urandom);
    it.requested_ma    = 14'($urandom);
    it.measured_bus_ma = 14'($urandom);
    it.protocol_ok     = 1'($urandom);
    it.table_addr      = 7'($urandom);
    it.load_value      = 16'($urandom);
    return it;
  endfunction

  // A tick that passes every protection check under the current settings,
  // wherever the settings leave room for one.
  function automatic policy_item_t healthy_tick();
    policy_item_t it;
    int hot, cold, soc_lim, vbat_lim;
    it = noise_item();
    it.op = OP_TICK;
    it.protocol_ok = 1'b1;
    hot = $signed(policy_word[CFG_HOT_PROTECT][8:0]);
    cold = $signed(policy_word[CFG_COLD_PROTECT][8:0]);
    soc_lim = policy_word[CFG_SOC_PROTECT][6:0];
    vbat_lim = policy_word[CFG_VBAT_PROTECT][12:0];
    if (hot - cold >= 2) begin
      it.battery_temp = 9'(cold + 1 + int'($urandom_range(0, hot - cold - 2)));
    end
    if (soc_lim < 127) it.charge_percent = 7'($urandom_range(soc_lim + 1, 127));
    if (vbat_lim < 8191) it.battery_mv = 13'($urandom_range(vbat_lim + 1, 8191));
    // Small bus currents keep the consumed power inside the table's reach.
    if ($urandom_range(0, 1)) it.measured_bus_ma = 14'($urandom_range(0, 3000));
    return it;
  endfunction

  // A comfortable computed tick under the reset settings.
  function automatic policy_item_t calm_tick();
    policy_item_t it;
    it = noise_item();
    it.op = OP_TICK;
    it.battery_temp = 9'sd25;
    it.charge_percent = 7'd50;
    it.battery_mv = 13'd4000;
    it.battery_ma = 16'sd1200;
    it.requested_mv = 15'd9000;
    it.requested_ma = 14'd2000;
    it.measured_bus_ma = 14'd500;
    it.protocol_ok = 1'b1;
    return it;
  endfunction

  function automatic logic signed [15:0] band_cap();
    case ($urandom_range(0, 7))
      0: return 16'sd0;
      1: return -16'($urandom_range(1, 32768));
      2: return 16'sd32767;
      default: return 16'($urandom_range(1, 16383));
    endcase
  endfunction

  // Span of values that each table is built around.
  function automatic void band_range(int tbl, output int lo, output int hi);
    case (tbl)
      TBL_SOC: begin lo = -1; hi = 127; end
      TBL_TEMP: begin lo = -257; hi = 255; end
      default: begin lo = -20000; hi = 32767; end
    endcase
  endfunction

  // Offers one item and waits for its transfer; the model is updated at the
  // accepting edge. Valid is left high so that a following item with no gap
  // goes out without a bubble.
  task automatic send_item(input policy_item_t it);
    int gap;
    gap = idle_cycles(src_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_op              <= it.op;
    in_battery_temp    <= it.battery_temp;
    in_charge_percent  <= it.charge_percent;
    in_battery_mv      <= it.battery_mv;
    in_battery_ma      <= it.battery_ma;
    in_requested_mv    <= it.requested_mv;
    in_requested_ma    <= it.requested_ma;
    in_measured_bus_ma <= it.measured_bus_ma;
    in_protocol_ok     <= it.protocol_ok;
    in_table_addr      <= it.table_addr;
    in_load_value      <= it.load_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_LOAD) apply_load(it.table_addr, it.load_value);
    else expected_limits.push_back(predict_limits(it));
  endtask

  task automatic send_load(input logic [TBL_W-1:0] tbl, input logic [LVL_W-1:0] lvl,
                           input logic [WRD_W-1:0] word, input logic signed [15:0] value);
    policy_item_t it;
    it = noise_item();
    it.op = OP_LOAD;
    it.table_addr = {tbl, lvl, word};
    it.load_value = value;
    send_item(it);
  endtask

  task automatic load_band_level(input logic [TBL_W-1:0] tbl, input logic [LVL_W-1:0] lvl,
                                 input int lo, input int hi, input logic signed [15:0] cap);
    send_load(tbl, lvl, WORD_HI, 16'(hi));
    send_load(tbl, lvl, WORD_LO, 16'(lo));
    send_load(tbl, lvl, WORD_LIM, cap);
  endtask

  // Rebuilds a whole table as a rough partition of its range. Jittered edges
  // leave small gaps and overlaps, some bands are turned inside out so that
  // they never match, and the level order is sometimes reversed.
  task automatic fill_band_table(input logic [TBL_W-1:0] tbl);
    int lo, hi, span, lvl, slot, b_lo, b_hi;
    bit reversed;
    band_range(tbl, lo, hi);
    span = (hi - lo) / LEVELS;
    reversed = 1'($urandom);
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      b_lo = lo + span * lvl + int'($urandom_range(0, span / 2)) - span / 4;
      b_hi = lo + span * (lvl + 1) + int'($urandom_range(0, span / 2)) - span / 4;
      if (lvl == 0) b_lo = lo;
      if (lvl == LEVELS - 1) b_hi = hi;
      slot = reversed ? LEVELS - 1 - lvl : lvl;
      if ($urandom_range(0, 7) == 0) load_band_level(tbl, slot, b_hi, b_lo, band_cap());
      else load_band_level(tbl, slot, b_lo, b_hi, band_cap());
    end
  endtask

  // Waits until every expected result has arrived and any trailing load has
  // had time to finish, so that registers may be written safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_limits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input policy_settings_t s);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= s[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    policy_word = s;
  endtask

  // Plausible thresholds; the unused upper bits of each word carry noise.
  function automatic policy_settings_t random_settings();
    policy_settings_t s;
    foreach (s[i]) s[i] = 15'($urandom);
    s[CFG_SOC_PROTECT][6:0] = 7'($urandom_range(0, 40));
    s[CFG_HOT_PROTECT][8:0] = 9'($urandom_range(30, 120));
    s[CFG_COLD_PROTECT][8:0] = 9'(-int'($urandom_range(0, 40)));
    s[CFG_VBAT_PROTECT][12:0] = 13'($urandom_range(2500, 4200));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings and empty tables: each fallback at and beside its
  // threshold, the priority between them, and field extremes.
  task automatic test_fallback_priority();
    policy_item_t it;
    it = calm_tick();
    send_item(it);                               // no band matches: drop is -1
    it.battery_temp = 9'sd50;  send_item(it);    // hot at the threshold
    it.battery_temp = 9'sd255; it.protocol_ok = 1'b0;
    send_item(it);                               // hot wins over a failed protocol
    it = calm_tick();
    it.battery_temp = 9'sd49;  send_item(it);
    it.battery_temp = 9'sd0;   send_item(it);    // cold at the threshold
    it.battery_temp = -9'sd256; send_item(it);
    it = calm_tick();
    it.battery_mv = 13'd3500;  send_item(it);
    it.battery_mv = 13'd3501;  send_item(it);
    it.battery_mv = 13'd0;     send_item(it);
    it = calm_tick();
    it.charge_percent = 7'd10; send_item(it);
    it.charge_percent = 7'd11; send_item(it);
    it.charge_percent = 7'd127;
    it.battery_ma = -16'sd32768;
    it.battery_mv = 13'd8191;
    it.requested_mv = 15'd32767;
    it.requested_ma = 14'd16383;
    it.measured_bus_ma = 14'd16383;
    send_item(it);
    it = calm_tick();
    it.protocol_ok = 1'b0;     send_item(it);
    it.charge_percent = 7'd0;  send_item(it);    // protection wins over protocol
    it = calm_tick();
    it.battery_ma = 16'sd32767;
    it.measured_bus_ma = 14'd0;
    it.requested_mv = 15'd0;
    it.requested_ma = 14'd0;
    send_item(it);
  endtask

  // Band edges, unloaded levels, zero and negative limits, the last level,
  // and loads aimed outside the tables.
  task automatic test_band_edges();
    policy_item_t it;
    load_band_level(TBL_SOC, 3'd0, 40, 60, 16'sd700);
    it = calm_tick();
    it.charge_percent = 7'd60; send_item(it);    // high edge is inside the band
    it.charge_percent = 7'd40; send_item(it);    // low edge is outside it
    load_band_level(TBL_TEMP, 3'd2, 20, 45, 16'sd0);
    it = calm_tick();
    it.battery_temp = 9'sd30;  send_item(it);    // a zero limit cuts nothing
    load_band_level(TBL_PWR, LAST_LVL, -32768, 32767, 16'sd300);
    send_item(it);
    send_load(2'd3, 3'd0, WORD_HI, 16'sd0);      // table three does not exist
    send_load(TBL_PWR, LAST_LVL, 2'd3, 16'sd5);  // nor does word three
    send_item(it);
    send_load(TBL_SOC, 3'd0, WORD_LIM, -16'sd7);
    send_item(it);                               // a negative charge limit reaches drop
    it.requested_ma = 14'd100; send_item(it);
    send_load(TBL_TEMP, 3'd2, WORD_LIM, 16'sd150);
    send_item(it);
  endtask

  // Register extremes, each followed by a burst of ticks and noise items over full tables.
  task automatic test_setting_extremes();
    policy_settings_t sweep [4];
    sweep[0] = '{default: 15'h0000};
    sweep[1] = '{default: 15'h7FFF};
    // Nearly everything computed, at the largest currents and ratio.
    sweep[2] = '{15'd0, 15'h00FF, 15'h0100, 15'd0, 15'h7FFF, 15'h3FFF, 15'h3FFF, 15'h00FF};
    // Tight limits at the top of the normal ranges and no consumption term.
    sweep[3] = '{15'd100, 15'h00C8, 15'h0138, 15'd8191, 15'd1, 15'd1, 15'd1, 15'd0};
    fill_band_table(TBL_SOC);
    fill_band_table(TBL_TEMP);
    fill_band_table(TBL_PWR);
    foreach (sweep[k]) begin
      settle();
      load_settings(sweep[k]);
      repeat (30) begin
        if ($urandom_range(0, 2) != 0) send_item(healthy_tick());
        else send_item(noise_item());
      end
    end
  endtask

  // Mostly ticks that reach the table walk, mixed with noise ticks, single
  // stray loads and rewrites of whole levels.
  task automatic test_random_traffic();
    policy_item_t it;
    int pick, lo, hi;
    logic [TBL_W-1:0] tbl;
    repeat (4) begin
      settle();
      load_settings(random_settings());
      fill_band_table(TBL_SOC);
      fill_band_table(TBL_TEMP);
      fill_band_table(TBL_PWR);
      repeat (400) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          send_item(healthy_tick());
        end else if (pick < 88) begin
          it = noise_item();
          it.op = OP_TICK;
          send_item(it);
        end else if (pick < 95) begin
          tbl = 2'($urandom_range(0, NTABLES - 1));
          band_range(tbl, lo, hi);
          lo = lo + int'($urandom_range(0, (hi - lo) / 2));
          hi = lo + int'($urandom_range(1, 200));
          load_band_level(tbl, 3'($urandom), lo, hi, band_cap());
        end else begin
          it = noise_item();
          it.op = OP_LOAD;
          send_item(it);
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while ticks arrive back to back,
  // so the output register fills and the input side has to stall.
  task automatic test_output_backpressure();
    settle();
    src_quiet = 60;
    drain_hold_req = 300;
    repeat (40) send_item(healthy_tick());
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: after each result transfer it draws a new stall length, or takes
  // the long pause when one has been asked for.
  initial begin
    int hold;
    @(posedge clk iff rst_n);
    forever begin
      if (drain_hold_req > 0) begin
        hold = drain_hold_req;
        drain_hold_req = 0;
      end else begin
        hold = idle_cycles(sink_quiet);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Each result transfer is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_limits.size() == 0) begin
        report_failure($sformatf("result with none expected: vbus %0d ibus %0d drop %0d mode %0d",
                                 out_bus_voltage_limit, out_bus_current_limit,
                                 out_drop_current, out_mode));
      end else begin
        want = expected_limits.pop_front();
        if (out_bus_voltage_limit !== want.vbus || out_bus_current_limit !== want.ibus ||
            out_drop_current !== want.drop || out_mode !== want.mode) begin
          report_failure($sformatf(
              "mismatch: expected vbus %0d ibus %0d drop %0d mode %0d, got %0d %0d %0d %0d",
              want.vbus, want.ibus, want.drop, want.mode, out_bus_voltage_limit,
              out_bus_current_limit, out_drop_current, out_mode));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Register words as they stand after reset, in index order.
    policy_word = '{15'd10, 15'd50, 15'd0, 15'd3500, 15'd5000, 15'd1000, 15'd500, 15'd10};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fallback_priority();
    test_band_edges();
    test_setting_extremes();
    test_random_traffic();
    test_output_backpressure();
    settle();
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
